FILE: src/wildcard_name_matcher_macros.svh
// Assertion macros shared by the wildcard name matcher modules.
`ifndef WILDCARD_NAME_MATCHER_MACROS_SVH
`define WILDCARD_NAME_MATCHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WNM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WNM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/wnm_pkg.sv
// Package with the types, constants and sizes of the wildcard name matcher.
`timescale 1ns / 1ps
`default_nettype none
package wnm_pkg;

  localparam int PATTERN_CHARS = 32;
  localparam int NAME_CHARS    = 64;

  localparam int PAT_LEN_W  = $clog2(PATTERN_CHARS + 1);
  localparam int PAT_IDX_W  = (PATTERN_CHARS > 1) ? $clog2(PATTERN_CHARS) : 1;
  localparam int NAME_LEN_W = $clog2(NAME_CHARS + 1);
  localparam int NAME_IDX_W = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;

  localparam logic [PAT_LEN_W-1:0]  PAT_FULL  = PAT_LEN_W'(PATTERN_CHARS);
  localparam logic [NAME_LEN_W-1:0] NAME_FULL = NAME_LEN_W'(NAME_CHARS);

  localparam logic ACT_PATTERN = 1'b0;
  localparam logic ACT_NAME    = 1'b1;

  localparam logic [7:0] CH_ANY_ONE = 8'h3F;
  localparam logic [7:0] CH_ANY_RUN = 8'h2A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef struct packed {
    logic       action;
    logic       has_char;
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL
  } wnm_state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic eval;
    logic deliver;
  } wnm_cmd_t;

  typedef struct packed {
    logic name_end;
    logic walk_done;
  } wnm_status_t;

endpackage
`default_nettype wire

FILE: src/wnm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module wnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: src/wnm_datapath.sv
// Datapath: character stores, lengths, overflow flags, walk pointers and result.
`timescale 1ns / 1ps
`default_nettype none
`include "wildcard_name_matcher_macros.svh"
module wnm_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wnm_pkg::in_item_t in_data_i,
  input  wire wnm_pkg::wnm_cmd_t cmd_i,
  output wnm_pkg::wnm_status_t   status_o,
  output wnm_pkg::out_item_t     out_data_o
);
  import wnm_pkg::*;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      return c - CH_LOWER_A + CH_UPPER_A;
    end
    return c;
  endfunction

  logic [PAT_LEN_W-1:0]  pat_len_q, pat_len_d;
  logic                  pat_open_q, pat_open_d;
  logic                  pat_ovf_q, pat_ovf_d;
  logic [NAME_LEN_W-1:0] name_len_q, name_len_d;
  logic                  name_ovf_q, name_ovf_d;
  logic [PAT_LEN_W-1:0]  pat_pos_q, pat_pos_d;
  logic [NAME_LEN_W-1:0] name_pos_q, name_pos_d;
  logic [PAT_LEN_W-1:0]  star_pos_q, star_pos_d;
  logic                  star_seen_q, star_seen_d;
  logic [NAME_LEN_W-1:0] resume_pos_q, resume_pos_d;
  out_item_t             out_q;

  logic                  is_pattern, is_name;
  logic [PAT_LEN_W-1:0]  pat_base;
  logic                  pat_we, name_we;
  logic [7:0]            pat_rd, name_rd;
  logic                  any_ovf, pat_empty;
  logic                  name_in, pat_in, at_star, char_hit;
  logic                  hit;

  assign is_pattern = cmd_i.load && (in_data_i.action == ACT_PATTERN);
  assign is_name    = cmd_i.load && (in_data_i.action == ACT_NAME);
  // A pattern item that arrives with no pattern open starts a fresh pattern.
  assign pat_base   = pat_open_q ? pat_len_q : '0;
  assign pat_we     = is_pattern && in_data_i.has_char && (pat_base < PAT_FULL);
  assign name_we    = is_name && in_data_i.has_char && (name_len_q < NAME_FULL);

  wnm_ram #(.WIDTH(8), .DEPTH(PATTERN_CHARS)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_base[PAT_IDX_W-1:0]),
    .wdata_i (in_data_i.char_code),
    .raddr_i (pat_pos_q[PAT_IDX_W-1:0]),
    .rdata_o (pat_rd)
  );

  wnm_ram #(.WIDTH(8), .DEPTH(NAME_CHARS)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (name_len_q[NAME_IDX_W-1:0]),
    .wdata_i (in_data_i.char_code),
    .raddr_i (name_pos_q[NAME_IDX_W-1:0]),
    .rdata_o (name_rd)
  );

  // One step of the backtracking walk on the bytes fetched in the previous cycle.
  assign any_ovf   = pat_ovf_q || name_ovf_q;
  assign pat_empty = (pat_len_q == '0);
  assign name_in   = (name_pos_q < name_len_q);
  assign pat_in    = (pat_pos_q < pat_len_q);
  assign at_star   = pat_in && (pat_rd == CH_ANY_RUN);
  assign char_hit  = pat_in && ((pat_rd == CH_ANY_ONE) || (upcase(pat_rd) == upcase(name_rd)));
  assign hit       = !any_ovf && (pat_empty || (!name_in && !pat_in));

  assign status_o.name_end  = (in_data_i.action == ACT_NAME) && in_data_i.last;
  assign status_o.walk_done = any_ovf || pat_empty ||
                              (name_in && !at_star && !char_hit && !star_seen_q) ||
                              (!name_in && !at_star);

  always_comb begin
    pat_len_d    = pat_len_q;
    pat_open_d   = pat_open_q;
    pat_ovf_d    = pat_ovf_q;
    name_len_d   = name_len_q;
    name_ovf_d   = name_ovf_q;
    pat_pos_d    = pat_pos_q;
    name_pos_d   = name_pos_q;
    star_pos_d   = star_pos_q;
    star_seen_d  = star_seen_q;
    resume_pos_d = resume_pos_q;

    if (is_pattern) begin
      pat_len_d  = pat_base;
      pat_ovf_d  = pat_open_q && pat_ovf_q;
      pat_open_d = !in_data_i.last;
      if (in_data_i.has_char) begin
        if (pat_we) begin
          pat_len_d = pat_base + PAT_LEN_W'(1);
        end else begin
          pat_ovf_d = 1'b1;
        end
      end
    end

    if (is_name && in_data_i.has_char) begin
      if (name_we) begin
        name_len_d = name_len_q + NAME_LEN_W'(1);
      end else begin
        name_ovf_d = 1'b1;
      end
    end

    if (cmd_i.start) begin
      pat_pos_d    = '0;
      name_pos_d   = '0;
      star_pos_d   = '0;
      star_seen_d  = 1'b0;
      resume_pos_d = '0;
    end

    if (cmd_i.eval) begin
      if (at_star) begin
        star_pos_d   = pat_pos_q;
        star_seen_d  = 1'b1;
        pat_pos_d    = pat_pos_q + PAT_LEN_W'(1);
        resume_pos_d = name_pos_q;
      end else if (name_in && char_hit) begin
        pat_pos_d  = pat_pos_q + PAT_LEN_W'(1);
        name_pos_d = name_pos_q + NAME_LEN_W'(1);
      end else begin
        // Retry the last star one name byte further on.
        pat_pos_d    = star_pos_q + PAT_LEN_W'(1);
        resume_pos_d = resume_pos_q + NAME_LEN_W'(1);
        name_pos_d   = resume_pos_q + NAME_LEN_W'(1);
      end
    end

    if (cmd_i.deliver) begin
      name_len_d = '0;
      name_ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q    <= '0;
      pat_open_q   <= 1'b0;
      pat_ovf_q    <= 1'b0;
      name_len_q   <= '0;
      name_ovf_q   <= 1'b0;
      pat_pos_q    <= '0;
      name_pos_q   <= '0;
      star_pos_q   <= '0;
      star_seen_q  <= 1'b0;
      resume_pos_q <= '0;
    end else begin
      pat_len_q    <= pat_len_d;
      pat_open_q   <= pat_open_d;
      pat_ovf_q    <= pat_ovf_d;
      name_len_q   <= name_len_d;
      name_ovf_q   <= name_ovf_d;
      pat_pos_q    <= pat_pos_d;
      name_pos_q   <= name_pos_d;
      star_pos_q   <= star_pos_d;
      star_seen_q  <= star_seen_d;
      resume_pos_q <= resume_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.deliver) begin
      out_q.matched  <= hit;
      out_q.overflow <= any_ovf;
    end
  end

  assign out_data_o = out_q;

  `WNM_ASSERT_SAME(a_resume_behind, clk_i, rst_ni, star_seen_q, resume_pos_q <= name_pos_q,
                   "resume position ran ahead of the name position")
  `WNM_ASSERT_SAME(a_star_behind, clk_i, rst_ni, star_seen_q, star_pos_q < pat_pos_q,
                   "star position is not behind the pattern position")
  `WNM_ASSERT_NEXT(a_name_cleared, clk_i, rst_ni, cmd_i.deliver,
                   name_len_q == '0 && !name_ovf_q, "name buffer not cleared after a result")

endmodule
`default_nettype wire

FILE: src/wnm_controller.sv
// Controller: state machine that sequences loading, the match walk and the result.
`timescale 1ns / 1ps
`default_nettype none
`include "wildcard_name_matcher_macros.svh"
module wnm_controller (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire wnm_pkg::wnm_status_t status_i,
  output wnm_pkg::wnm_cmd_t         cmd_o
);
  import wnm_pkg::*;

  wnm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.name_end) begin
            cmd_o.start = 1'b1;
            state_d     = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.walk_done) begin
          // The result waits here until the output register is free.
          if (out_free) begin
            cmd_o.deliver = 1'b1;
            out_valid_d   = 1'b1;
            state_d       = ST_IDLE;
          end
        end else begin
          cmd_o.eval = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `WNM_ASSERT_SAME(a_deliver_free, clk_i, rst_ni, cmd_o.deliver, out_free,
                   "result written over an item not yet taken")
  `WNM_ASSERT_NEXT(a_name_end_walks, clk_i, rst_ni, in_valid_i && !in_stall_o && status_i.name_end,
                   state_q == ST_FETCH, "end of a name did not start the walk")
  `WNM_ASSERT_NEXT(a_step_refetch, clk_i, rst_ni, cmd_o.eval,
                   state_q == ST_FETCH && in_stall_o, "walk step did not fetch again")

endmodule
`default_nettype wire

FILE: src/wildcard_name_matcher.sv
// Flow: a pattern item, or a name item that is not the last, is taken in the idle state.
// The last item of a name starts the walk; its result is registered when the walk ends
// and the output register is free. The walk has S steps, at most about name length times
// pattern length; each step is one fetch from the two RAMs and one compare.
// Input is stalled during the walk. Reset clears lengths, flags and control state;
// the character stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module wildcard_name_matcher (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire wnm_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output wnm_pkg::out_item_t     out_data_o
);
  import wnm_pkg::*;

  wnm_cmd_t    cmd;
  wnm_status_t status;

  wnm_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wnm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
